FILE: src/assert_macros.svh
// Assertion macros for the particle pool integrator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: src/ppi_pkg.sv
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared constants and types of the particle pool integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;
   localparam int POOL_DEPTH = 64;
   localparam int STEP_SCALE = 1092;
   localparam logic [0:0] OP_ADD  = 1'b0;
   localparam logic [0:0] OP_TICK = 1'b1;
   localparam logic [2:0] REG_CAPACITY = 3'd0;
   localparam logic [2:0] REG_LIFETIME = 3'd1;
   localparam logic [2:0] REG_FRICTION = 3'd2;
   localparam logic [2:0] REG_WIND_X   = 3'd3;
   localparam logic [2:0] REG_WIND_Y   = 3'd4;
   localparam logic [2:0] REG_WIND_Z   = 3'd5;

   // One particle as held in the store.
   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] pz;
      logic [31:0] vx;
      logic [31:0] vy;
      logic [31:0] vz;
      logic [15:0] age;
   } particle_type;

   // Signed 32 x unsigned 16, arithmetic shift by 16, low 32 bits.
   function automatic logic [31:0] mul_q16(input logic [31:0] a, input logic [15:0] b);
      logic signed [48:0] p;
      begin
         p = $signed(a) * $signed({1'b0, b});
         mul_q16 = p[47:16];
      end
   endfunction
endpackage

FILE: src/ppi_store.sv
// ----------------------------------------------------------------------------
// ppi_store
// Particle memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppi_store #(
   parameter int DEPTH = ppi_pkg::POOL_DEPTH,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  ppi_pkg::particle_type wr_data,
   input  logic [AW-1:0]         rd_addr,
   output ppi_pkg::particle_type rd_data
);
   ppi_pkg::particle_type mem [DEPTH];
   ppi_pkg::particle_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

FILE: src/ppi_euler.sv
// ----------------------------------------------------------------------------
// ppi_euler
// One Euler frame over three axes: a registered multiply, then a combinational add.
// ----------------------------------------------------------------------------
module ppi_euler (
   input  logic                  clock,
   input  ppi_pkg::particle_type in_p,
   input  logic [15:0]           friction,
   input  logic [31:0]           wind_x,
   input  logic [31:0]           wind_y,
   input  logic [31:0]           wind_z,
   output ppi_pkg::particle_type out_p
);
   localparam logic [15:0] SCALE = 16'(ppi_pkg::STEP_SCALE);
   logic [31:0] dx_ff, dy_ff, dz_ff, fx_ff, fy_ff, fz_ff;
   ppi_pkg::particle_type hold_ff;

   always_ff @(posedge clock) begin
      dx_ff   <= ppi_pkg::mul_q16(in_p.vx, SCALE);
      dy_ff   <= ppi_pkg::mul_q16(in_p.vy, SCALE);
      dz_ff   <= ppi_pkg::mul_q16(in_p.vz, SCALE);
      fx_ff   <= ppi_pkg::mul_q16(in_p.vx, friction);
      fy_ff   <= ppi_pkg::mul_q16(in_p.vy, friction);
      fz_ff   <= ppi_pkg::mul_q16(in_p.vz, friction);
      hold_ff <= in_p;
   end

   always_comb begin
      out_p    = hold_ff;
      out_p.px = hold_ff.px + dx_ff;
      out_p.py = hold_ff.py + dy_ff;
      out_p.pz = hold_ff.pz + dz_ff;
      out_p.vx = fx_ff + wind_x;
      out_p.vy = fy_ff + wind_y;
      out_p.vz = fz_ff + wind_z;
   end
endmodule

FILE: src/particle_pool_integrator_top.sv
// ----------------------------------------------------------------------------
// particle_pool_integrator_top
// Particle pool with add and tick commands and a memory-held state.
// ----------------------------------------------------------------------------
// Channel  Ports                      Direction
// req      start / busy               in, accepted on start and not busy
// rsp      rsp_valid                  out, one cycle per item, no stall
// csr      csr_valid / csr_ready      in, write of index and data
//
// An add writes the new particle if capacity allows. A tick reads each particle in
// turn through the single read port of the memory and steps each survivor through
// the shared Euler unit (multiply, then add) once per frame.
// Each report is held until the next survivor or the end of the tick is known,
// so the last flag is exact. Reset is synchronous and clears control state;
// memory holds garbage until written. Results cannot be stalled.
`include "assert_macros.svh"
module particle_pool_integrator_top #(
   parameter int POOL_DEPTH = ppi_pkg::POOL_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [0:0]  req_opcode,
   input  logic [3:0]  req_frames,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_start_z,
   input  logic [31:0] req_start_vx,
   input  logic [31:0] req_start_vy,
   input  logic [31:0] req_start_vz,
   output logic        rsp_valid,
   output logic [5:0]  rsp_slot,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic [15:0] rsp_age,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_WAIT  = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [3:0]    frames_ff, frames_in, fcnt_ff, fcnt_in;
   logic [6:0]    cap_ff, cap_in;
   logic [15:0]   life_ff, fric_ff;
   logic [31:0]   wx_ff, wy_ff, wz_ff;
   ppi_pkg::particle_type cur_ff, cur_in;
   logic          rv_ff, rl_ff, rv_in, rl_in;
   logic          pend_ff, pend_in;
   logic          ph_ff;
   logic [5:0]    rs_ff;
   ppi_pkg::particle_type rp_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   ppi_pkg::particle_type wr_data, rd_data, step_out;
   logic [16:0]   age_sum;
   logic [15:0]   age_sat;
   logic [CW-1:0] last_idx;

   ppi_store #(.DEPTH(POOL_DEPTH), .AW(AW)) u_store (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );
   ppi_euler u_euler (
      .clock(clock), .in_p(cur_ff), .friction(fric_ff),
      .wind_x(wx_ff), .wind_y(wy_ff), .wind_z(wz_ff), .out_p(step_out)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign age_sum   = {1'b0, rd_data.age} + 17'(frames_ff);
   assign age_sat   = age_sum[16] ? 16'hFFFF : age_sum[15:0];
   assign last_idx  = count_ff - CW'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      frames_in = frames_ff;
      fcnt_in   = fcnt_ff;
      cap_in    = cap_ff;
      cur_in    = cur_ff;
      rv_in     = 1'b0;
      rl_in     = 1'b0;
      pend_in   = pend_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff[AW-1:0];
      wr_data   = cur_ff;
      rd_addr   = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start && req_opcode == ppi_pkg::OP_ADD) begin
               if (CW'(count_ff) < CW'(cap_ff) && count_ff < DEPTH_C) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[AW-1:0];
                  wr_data  = '{req_start_x, req_start_y, req_start_z,
                               req_start_vx, req_start_vy, req_start_vz, 16'd0};
                  count_in = count_ff + CW'(1);
               end
               state_in = S_DONE;
            end else if (start) begin
               frames_in = req_frames;
               idx_in    = '0;
               pend_in   = 1'b0;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            // The memory address already carries idx; data arrives next cycle.
            if (idx_ff < count_ff) begin
               state_in = S_CHECK;
            end else begin
               // End of the tick: the held report is the last one.
               rv_in    = pend_ff;
               rl_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_CHECK: begin
            cur_in     = rd_data;
            cur_in.age = age_sat;
            fcnt_in    = frames_ff;
            if (age_sat >= life_ff) begin
               // Expired: move the last particle here and revisit this slot.
               count_in = last_idx;
               rd_addr  = last_idx[AW-1:0];
               if (last_idx <= idx_ff) begin
                  // The expired particle was the last one: the tick ends here.
                  rv_in    = pend_ff;
                  rl_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_WAIT;
               end
            end else begin
               // Another survivor follows, so the held report is not the last.
               rv_in    = pend_ff;
               state_in = S_STEP;
            end
         end
         S_WAIT: begin
            // The moved particle is read again from the memory in S_CHECK.
            wr_en    = 1'b1;
            wr_data  = rd_data;
            state_in = S_READ;
         end
         S_STEP: begin
            if (fcnt_ff == 4'd0) begin
               wr_en    = 1'b1;
               idx_in   = idx_ff + CW'(1);
               rd_addr  = idx_in[AW-1:0];
               pend_in  = 1'b1;
               state_in = S_READ;
            end else begin
               if (ph_ff) begin
                  fcnt_in = fcnt_ff - 4'd1;
               end
               state_in = S_STEP;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (csr_valid && csr_ready && csr_index == ppi_pkg::REG_CAPACITY) begin
         cap_in = (csr_data[6:0] > 7'(POOL_DEPTH)) ? 7'(POOL_DEPTH) : csr_data[6:0];
         if (count_in > CW'(cap_in)) count_in = CW'(cap_in);
      end
   end

   // Control state, frame sequencing through the Euler unit, and settings writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         cap_ff   <= 7'd0;
         life_ff  <= 16'd120;
         fric_ff  <= 16'd58982;
         wx_ff    <= '0;
         wy_ff    <= '0;
         wz_ff    <= '0;
         rv_ff    <= 1'b0;
         rl_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         ph_ff    <= 1'b0;
         fcnt_ff  <= '0;
         frames_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         frames_ff <= frames_in;
         fcnt_ff   <= fcnt_in;
         cap_ff    <= cap_in;
         rv_ff     <= rv_in;
         rl_ff     <= rl_in;
         pend_ff   <= pend_in;
         ph_ff     <= (state_ff == S_STEP && fcnt_ff != 4'd0) ? !ph_ff : 1'b0;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ppi_pkg::REG_LIFETIME: life_ff <= csr_data[15:0];
               ppi_pkg::REG_FRICTION: fric_ff <= csr_data[15:0];
               ppi_pkg::REG_WIND_X:   wx_ff   <= csr_data;
               ppi_pkg::REG_WIND_Y:   wy_ff   <= csr_data;
               ppi_pkg::REG_WIND_Z:   wz_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CHECK) begin
         cur_ff <= cur_in;
      end else if (state_ff == S_STEP && fcnt_ff != 4'd0 && ph_ff) begin
         cur_ff <= step_out;
      end
      if (state_ff == S_STEP && fcnt_ff == 4'd0) begin
         rs_ff <= 6'(idx_ff);
         rp_ff <= cur_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_last  = rl_ff;
   assign rsp_slot  = rs_ff;
   assign rsp_out_x = rp_ff.px;
   assign rsp_out_y = rp_ff.py;
   assign rsp_out_z = rp_ff.pz;
   assign rsp_age   = rp_ff.age;

   `ASSERT_IMPLIES(a_count_cap, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `ASSERT_NEXT(a_add_done, clock, reset, start && !busy && req_opcode == ppi_pkg::OP_ADD, busy && !rsp_valid)
   `ASSERT_IMPLIES(a_rsp_busy, clock, reset, rsp_valid, $past(busy))
endmodule
